// ===== hw/rtl/ecdma_pkg.sv =====
// Shared types, constants and helpers of the eight-channel DMA controller.
package ecdma_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_BPORT  = 3'd1;
  localparam logic [2:0] REG_A_LO   = 3'd2;
  localparam logic [2:0] REG_A_HI   = 3'd3;
  localparam logic [2:0] REG_A_BANK = 3'd4;
  localparam logic [2:0] REG_CNT_LO = 3'd5;
  localparam logic [2:0] REG_CNT_HI = 3'd6;

  localparam logic [13:0] B_PORT_BASE = 14'h2100;
  localparam logic [16:0] FULL_COUNT  = 17'h10000;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       ch_ok;
    logic [2:0] channel;
    logic [2:0] reg_index;
    logic [7:0] wdata;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        copy_valid;
    logic [23:0] copy_source;
    logic [23:0] copy_dest;
    logic        busy_res;
  } res_t;

  function automatic logic [1:0] b_offset(input logic [2:0] mode, input logic [1:0] phase);
    logic [1:0] off;
    unique case (mode)
      3'd1, 3'd5: off = {1'b0, phase[0]};
      3'd3, 3'd7: off = {1'b0, phase[1]};
      3'd4:       off = phase;
      default:    off = 2'd0;
    endcase
    return off;
  endfunction

endpackage

// ===== hw/rtl/eight_channel_dma_controller_unit.sv =====
// Top level of the eight-channel DMA controller: front end, command queue, engine.
// Requests (register write, register read, start mask, tick) are pushed in and
// each yields exactly one result, popped in order. A two-entry command queue
// parts the decode front end from the engine, and a two-entry result queue
// parts the engine from the consumer. The engine executes one request per
// clock, combinationally over flip-flop channel registers, so the block
// sustains one transfer per cycle on each side while neither side stalls;
// a request is registered in the command queue, and its result in the result queue.
// A tick moves one byte of the active channel, first taking the lowest pending
// channel when none is active, and reports its source and destination addresses.
module eight_channel_dma_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  in_opcode,
  input  logic [2:0]  in_channel,
  input  logic [2:0]  in_reg_index,
  input  logic [7:0]  in_wdata,
  input  logic        push,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_rdata,
  output logic        out_copy_valid,
  output logic [23:0] out_copy_source,
  output logic [23:0] out_copy_dest,
  output logic        out_busy_res
);
  import ecdma_pkg::*;

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;
  res_t res_head;

  ecdma_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_opcode    (in_opcode),
    .in_channel   (in_channel),
    .in_reg_index (in_reg_index),
    .in_wdata     (in_wdata),
    .in_push      (push),
    .in_full      (full),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  ecdma_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_empty (empty),
    .out_pop   (pop),
    .res_head  (res_head)
  );

  assign out_rdata       = res_head.rdata;
  assign out_copy_valid  = res_head.copy_valid;
  assign out_copy_source = res_head.copy_source;
  assign out_copy_dest   = res_head.copy_dest;
  assign out_busy_res    = res_head.busy_res;

endmodule

// ===== hw/rtl/ecdma_front.sv =====
// Front end: accepts and decodes requests into a two-entry command queue.
module ecdma_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_opcode,
  input  logic [2:0]        in_channel,
  input  logic [2:0]        in_reg_index,
  input  logic [7:0]        in_wdata,
  input  logic              in_push,
  output logic              in_full,
  output logic              cmd_valid,
  output ecdma_pkg::cmd_t   cmd,
  input  logic              cmd_take
);
  import ecdma_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;
  cmd_t       dec;

  always_comb begin
    dec.op        = op_t'(in_opcode);
    dec.ch_ok     = ({1'b0, in_channel} < 4'(CHANNELS));
    dec.channel   = in_channel;
    dec.reg_index = in_reg_index;
    dec.wdata     = in_wdata;
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_take && cmd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ===== hw/rtl/ecdma_back.sv =====
// Back end: channel registers, transfer engine and two-entry result queue.
module ecdma_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  ecdma_pkg::cmd_t   cmd,
  output logic              cmd_take,
  output logic              out_empty,
  input  logic              out_pop,
  output ecdma_pkg::res_t   res_head
);
  import ecdma_pkg::*;

  logic              dir_r   [CHANNELS];
  logic              dir_nxt [CHANNELS];
  logic              rev_r   [CHANNELS];
  logic              rev_nxt [CHANNELS];
  logic              hold_r  [CHANNELS];
  logic              hold_nxt[CHANNELS];
  logic [2:0]        mode_r  [CHANNELS];
  logic [2:0]        mode_nxt[CHANNELS];
  logic [23:0]       a_addr_r  [CHANNELS];
  logic [23:0]       a_addr_nxt[CHANNELS];
  logic [13:0]       b_addr_r  [CHANNELS];
  logic [13:0]       b_addr_nxt[CHANNELS];
  logic [15:0]       count_r   [CHANNELS];
  logic [15:0]       count_nxt [CHANNELS];
  logic [CHANNELS-1:0] pending_r, pending_nxt;
  logic [CH_W-1:0]   cur_ch_r, cur_ch_nxt;
  logic [16:0]       remain_r, remain_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic              active_r, active_nxt;

  res_t              rq_r [2];
  logic              rq_wr_r, rq_rd_r;
  logic [1:0]        rq_cnt_r, rq_cnt_nxt;
  logic              do_pop;

  res_t              res;
  logic [CH_W-1:0]   wch;
  logic [CH_W-1:0]   low_ch;
  logic              start;
  logic [CH_W-1:0]   eng_ch;
  logic [16:0]       rem;
  logic [1:0]        phase;
  logic [23:0]       a_cur;
  logic [23:0]       b_cur;

  assign cmd_take  = cmd_valid && (rq_cnt_r != 2'd2);
  assign out_empty = (rq_cnt_r == 2'd0);
  assign res_head  = rq_r[rq_rd_r];
  assign do_pop    = out_pop && !out_empty;
  assign wch       = cmd.channel[CH_W-1:0];

  always_comb begin
    low_ch = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (pending_r[i]) begin
        low_ch = CH_W'(i);
      end
    end
  end

  always_comb begin
    dir_nxt     = dir_r;
    rev_nxt     = rev_r;
    hold_nxt    = hold_r;
    mode_nxt    = mode_r;
    a_addr_nxt  = a_addr_r;
    b_addr_nxt  = b_addr_r;
    count_nxt   = count_r;
    pending_nxt = pending_r;
    cur_ch_nxt  = cur_ch_r;
    remain_nxt  = remain_r;
    phase_nxt   = phase_r;
    active_nxt  = active_r;
    res         = '0;
    start       = !active_r && (pending_r != '0);
    eng_ch      = start ? low_ch : cur_ch_r;
    rem         = start ? ((count_r[low_ch] == 16'd0) ? FULL_COUNT : {1'b0, count_r[low_ch]})
                        : remain_r;
    phase       = start ? 2'd0 : phase_r;
    a_cur       = a_addr_r[eng_ch];
    b_cur       = 24'(b_addr_r[eng_ch]) + 24'(b_offset(mode_r[eng_ch], phase));
    unique case (cmd.op)
      OP_WRITE: begin
        if (cmd.ch_ok) begin
          unique case (cmd.reg_index)
            REG_CTRL: begin
              dir_nxt[wch]  = cmd.wdata[7];
              rev_nxt[wch]  = cmd.wdata[4];
              hold_nxt[wch] = cmd.wdata[3];
              mode_nxt[wch] = cmd.wdata[2:0];
            end
            REG_BPORT:  b_addr_nxt[wch] = B_PORT_BASE | {6'd0, cmd.wdata};
            REG_A_LO:   a_addr_nxt[wch][7:0]   = cmd.wdata;
            REG_A_HI:   a_addr_nxt[wch][15:8]  = cmd.wdata;
            REG_A_BANK: a_addr_nxt[wch][23:16] = cmd.wdata;
            REG_CNT_LO: count_nxt[wch][7:0]    = cmd.wdata;
            REG_CNT_HI: count_nxt[wch][15:8]   = cmd.wdata;
            default: ;
          endcase
        end
      end
      OP_READ: begin
        if (cmd.ch_ok) begin
          unique case (cmd.reg_index)
            REG_CTRL:   res.rdata = {dir_r[wch], 2'b00, rev_r[wch], hold_r[wch], mode_r[wch]};
            REG_BPORT:  res.rdata = b_addr_r[wch][7:0];
            REG_A_LO:   res.rdata = a_addr_r[wch][7:0];
            REG_A_HI:   res.rdata = a_addr_r[wch][15:8];
            REG_A_BANK: res.rdata = a_addr_r[wch][23:16];
            REG_CNT_LO: res.rdata = count_r[wch][7:0];
            REG_CNT_HI: res.rdata = count_r[wch][15:8];
            default:    res.rdata = 8'd0;
          endcase
        end
      end
      OP_START: begin
        pending_nxt = pending_r | cmd.wdata[CHANNELS-1:0];
      end
      OP_TICK: begin
        if (start) begin
          pending_nxt[low_ch] = 1'b0;
        end
        if (active_r || start) begin
          res.copy_valid  = 1'b1;
          res.copy_source = dir_r[eng_ch] ? b_cur : a_cur;
          res.copy_dest   = dir_r[eng_ch] ? a_cur : b_cur;
          if (!hold_r[eng_ch]) begin
            a_addr_nxt[eng_ch] = rev_r[eng_ch] ? (a_cur - 24'd1) : (a_cur + 24'd1);
          end
          cur_ch_nxt = eng_ch;
          phase_nxt  = phase + 2'd1;
          remain_nxt = rem - 17'd1;
          if (rem == 17'd1) begin
            count_nxt[eng_ch] = 16'd0;
            active_nxt        = 1'b0;
          end else begin
            active_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.busy_res = active_nxt || (pending_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        dir_r[i]    <= 1'b0;
        rev_r[i]    <= 1'b0;
        hold_r[i]   <= 1'b0;
        mode_r[i]   <= 3'd0;
        a_addr_r[i] <= 24'd0;
        b_addr_r[i] <= 14'd0;
        count_r[i]  <= 16'd0;
      end
      pending_r <= '0;
      cur_ch_r  <= '0;
      remain_r  <= 17'd0;
      phase_r   <= 2'd0;
      active_r  <= 1'b0;
    end else if (cmd_take) begin
      dir_r     <= dir_nxt;
      rev_r     <= rev_nxt;
      hold_r    <= hold_nxt;
      mode_r    <= mode_nxt;
      a_addr_r  <= a_addr_nxt;
      b_addr_r  <= b_addr_nxt;
      count_r   <= count_nxt;
      pending_r <= pending_nxt;
      cur_ch_r  <= cur_ch_nxt;
      remain_r  <= remain_nxt;
      phase_r   <= phase_nxt;
      active_r  <= active_nxt;
    end
  end

  assign rq_cnt_nxt = rq_cnt_r + 2'(cmd_take) - 2'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= 1'b0;
      rq_rd_r  <= 1'b0;
      rq_cnt_r <= 2'd0;
    end else begin
      if (cmd_take) begin
        rq_wr_r <= ~rq_wr_r;
      end
      if (do_pop) begin
        rq_rd_r <= ~rq_rd_r;
      end
      rq_cnt_r <= rq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      rq_r[rq_wr_r] <= res;
    end
  end

endmodule

// ===== hw/rtl/ecdma_checker.sv =====
// Port-level checker of the eight-channel DMA controller and its bind.
module ecdma_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic [7:0]  out_rdata,
  input logic        out_copy_valid,
  input logic [23:0] out_copy_source,
  input logic [23:0] out_copy_dest
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  a_no_copy_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_copy_valid |-> out_copy_source == 24'd0 && out_copy_dest == 24'd0)
    else $error("addresses on a result without a copy");

  a_copy_no_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_copy_valid |-> out_rdata == 8'd0)
    else $error("read data on a copy result");

endmodule

bind eight_channel_dma_controller_unit ecdma_checker u_ecdma_checker (.*);

// ===== tb/tb_eight_channel_dma_controller_unit.sv =====
// Testbench for the eight-channel DMA controller: directed and random request traffic checked in order.

class dma_copy_scoreboard;
  logic        b_to_a    [8];
  logic        step_down [8];
  logic        hold_addr [8];
  logic [2:0]  mode      [8];
  logic [23:0] a_addr    [8];
  logic [13:0] b_addr    [8];
  logic [15:0] count     [8];
  logic [7:0]  queued;
  logic [2:0]  cur_ch;
  logic [16:0] left;
  logic [1:0]  phase;
  logic        active;
  ecdma_pkg::res_t expected_results[$];
  int mismatches;
  int results_seen;
  int bytes_copied;

  function new();
    for (int i = 0; i < 8; i++) begin
      b_to_a[i] = 1'b0;
      step_down[i] = 1'b0;
      hold_addr[i] = 1'b0;
      mode[i] = '0;
      a_addr[i] = '0;
      b_addr[i] = '0;
      count[i] = '0;
    end
    queued = '0;
    cur_ch = '0;
    left = '0;
    phase = '0;
    active = 1'b0;
    mismatches = 0;
    results_seen = 0;
    bytes_copied = 0;
  endfunction

  function void note_request(ecdma_pkg::op_t op, logic [2:0] ch, logic [2:0] idx,
                             logic [7:0] d);
    ecdma_pkg::res_t r;
    logic [2:0] c;
    logic [1:0] off;
    logic [23:0] a;
    logic [23:0] b;
    r = '0;
    case (op)
      ecdma_pkg::OP_WRITE: begin
        case (idx)
          ecdma_pkg::REG_CTRL: begin
            b_to_a[ch] = d[7];
            step_down[ch] = d[4];
            hold_addr[ch] = d[3];
            mode[ch] = d[2:0];
          end
          ecdma_pkg::REG_BPORT:  b_addr[ch] = ecdma_pkg::B_PORT_BASE | {6'd0, d};
          ecdma_pkg::REG_A_LO:   a_addr[ch][7:0] = d;
          ecdma_pkg::REG_A_HI:   a_addr[ch][15:8] = d;
          ecdma_pkg::REG_A_BANK: a_addr[ch][23:16] = d;
          ecdma_pkg::REG_CNT_LO: count[ch][7:0] = d;
          ecdma_pkg::REG_CNT_HI: count[ch][15:8] = d;
          default: ;
        endcase
      end
      ecdma_pkg::OP_READ: begin
        case (idx)
          ecdma_pkg::REG_CTRL:
            r.rdata = {b_to_a[ch], 2'b00, step_down[ch], hold_addr[ch], mode[ch]};
          ecdma_pkg::REG_BPORT:  r.rdata = b_addr[ch][7:0];
          ecdma_pkg::REG_A_LO:   r.rdata = a_addr[ch][7:0];
          ecdma_pkg::REG_A_HI:   r.rdata = a_addr[ch][15:8];
          ecdma_pkg::REG_A_BANK: r.rdata = a_addr[ch][23:16];
          ecdma_pkg::REG_CNT_LO: r.rdata = count[ch][7:0];
          ecdma_pkg::REG_CNT_HI: r.rdata = count[ch][15:8];
          default:               r.rdata = 8'd0;
        endcase
      end
      ecdma_pkg::OP_START: queued = queued | d;
      default: begin
        if (!active && queued != 8'd0) begin
          for (int i = 7; i >= 0; i--)
            if (queued[i]) cur_ch = 3'(i);
          queued[cur_ch] = 1'b0;
          left = (count[cur_ch] == 16'd0) ? ecdma_pkg::FULL_COUNT : {1'b0, count[cur_ch]};
          phase = 2'd0;
          active = 1'b1;
        end
        if (active) begin
          c = cur_ch;
          a = a_addr[c];
          if (mode[c] == 3'd4) off = phase;
          else if (mode[c][0]) off = {1'b0, mode[c][1] ? phase[1] : phase[0]};
          else off = 2'd0;
          b = {10'd0, b_addr[c]} + {22'd0, off};
          r.copy_valid = 1'b1;
          r.copy_source = b_to_a[c] ? b : a;
          r.copy_dest = b_to_a[c] ? a : b;
          bytes_copied++;
          if (!hold_addr[c]) a_addr[c] = step_down[c] ? a - 24'd1 : a + 24'd1;
          phase = phase + 2'd1;
          left = left - 17'd1;
          if (left == 17'd0) begin
            count[c] = 16'd0;
            active = 1'b0;
          end
        end
      end
    endcase
    r.busy_res = active || (queued != 8'd0);
    expected_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [23:0] want, logic [23:0] got, time stamp);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", stamp, name, want, got);
    end
  endfunction

  function void check_result(ecdma_pkg::res_t got, time stamp);
    ecdma_pkg::res_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, expected none, actual %0h", stamp, got);
      return;
    end
    want = expected_results.pop_front();
    compare_field("rdata", 24'(want.rdata), 24'(got.rdata), stamp);
    compare_field("copy_valid", 24'(want.copy_valid), 24'(got.copy_valid), stamp);
    compare_field("copy_source", want.copy_source, got.copy_source, stamp);
    compare_field("copy_dest", want.copy_dest, got.copy_dest, stamp);
    compare_field("busy_res", 24'(want.busy_res), 24'(got.busy_res), stamp);
  endfunction
endclass

module tb_eight_channel_dma_controller_unit;
  import ecdma_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [2:0] LONG_CH = 3'd5;
  localparam int RANDOM_ITEMS = 1080;
  localparam int HOLD_CYCLES = 120;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [1:0]  in_opcode = '0;
  logic [2:0]  in_channel = '0;
  logic [2:0]  in_reg_index = '0;
  logic [7:0]  in_wdata = '0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  out_rdata;
  logic        out_copy_valid;
  logic [23:0] out_copy_source;
  logic [23:0] out_copy_dest;
  logic        out_busy_res;

  dma_copy_scoreboard sb;
  int sent_items = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int rx_wait = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  eight_channel_dma_controller_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_opcode      (in_opcode),
    .in_channel     (in_channel),
    .in_reg_index   (in_reg_index),
    .in_wdata       (in_wdata),
    .push           (push),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .out_rdata      (out_rdata),
    .out_copy_valid (out_copy_valid),
    .out_copy_source(out_copy_source),
    .out_copy_dest  (out_copy_dest),
    .out_busy_res   (out_busy_res)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] startable();
    logic [7:0] m;
    m = '0;
    for (int i = 0; i < CHANNELS; i++)
      if (sb.count[i] != 16'd0 && sb.count[i] <= 16'd600 && !(sb.active && sb.cur_ch == 3'(i)))
        m[i] = 1'b1;
    return m;
  endfunction

  function automatic int backlog();
    int n;
    n = sb.active ? int'(sb.left) : 0;
    for (int i = 0; i < CHANNELS; i++)
      if (sb.queued[i]) n += (sb.count[i] == 16'd0) ? 65536 : int'(sb.count[i]);
    return n;
  endfunction

  always @(posedge clk) begin : rx_side
    int gap;
    if (rst_n && pop && !empty)
      sb.check_result({out_rdata, out_copy_valid, out_copy_source, out_copy_dest, out_busy_res},
                      $time);
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (rx_wait > 0) begin
      pop <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else if (hold_done != hold_reqs) begin
      pop <= 1'b0;
      rx_wait <= HOLD_CYCLES;
      hold_done <= hold_reqs;
    end else if (rx_steady) begin
      pop <= 1'b1;
    end else begin
      gap = idle_len();
      pop <= (gap == 0);
      rx_wait <= (gap > 0) ? gap - 1 : 0;
    end
  end

  task automatic send(input op_t op, input logic [2:0] ch, input logic [2:0] idx,
                      input logic [7:0] d);
    int gap;
    in_opcode <= op;
    in_channel <= ch;
    in_reg_index <= idx;
    in_wdata <= d;
    push <= 1'b1;
    do @(posedge clk); while (full);
    sb.note_request(op, ch, idx, d);
    sent_items++;
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    if (sb.expected_results.size() != 0) begin
      push <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clk);
    end
  endtask

  task automatic program_and_run();
    logic [2:0] ch;
    logic [7:0] free;
    logic [7:0] lo;
    logic [7:0] hi;
    int r;
    free = ~sb.queued;
    if (sb.active) free[sb.cur_ch] = 1'b0;
    if (free == 8'd0) begin
      repeat (20) send(OP_TICK, 3'($urandom), 3'($urandom), 8'($urandom));
      return;
    end
    do ch = 3'($urandom); while (!free[ch]);
    send(OP_WRITE, ch, REG_CTRL, 8'($urandom));
    send(OP_WRITE, ch, REG_BPORT, 8'($urandom));
    r = $urandom_range(0, 9);
    send(OP_WRITE, ch, REG_A_LO, (r == 0) ? 8'hFE : (r == 1) ? 8'h01 : 8'($urandom));
    send(OP_WRITE, ch, REG_A_HI, (r == 0) ? 8'hFF : (r == 1) ? 8'h00 : 8'($urandom));
    send(OP_WRITE, ch, REG_A_BANK, (r == 0) ? 8'hFF : (r == 1) ? 8'h00 : 8'($urandom));
    r = $urandom_range(0, 99);
    if (r < 85) begin
      lo = 8'($urandom_range(1, 12));
      hi = 8'h00;
    end else if (r < 97) begin
      lo = 8'($urandom_range(13, 64));
      hi = 8'h00;
    end else begin
      lo = 8'($urandom);
      hi = 8'h01;
    end
    send(OP_WRITE, ch, REG_CNT_LO, lo);
    send(OP_WRITE, ch, REG_CNT_HI, hi);
    send(OP_START, 3'($urandom), 3'($urandom), (8'd1 << ch) | (8'($urandom) & startable()));
    repeat ($urandom_range(4, 24)) begin
      r = $urandom_range(0, 99);
      if (r < 80)
        send(OP_TICK, 3'($urandom), 3'($urandom), 8'($urandom));
      else if (r < 90)
        send(OP_READ, 3'($urandom), 3'($urandom), 8'($urandom));
      else
        send(OP_WRITE, sb.cur_ch, 3'($urandom_range(0, 4)), 8'($urandom));
    end
  endtask

  task automatic noise_burst();
    op_t op;
    logic [2:0] ch;
    logic [2:0] idx;
    logic [7:0] d;
    repeat ($urandom_range(1, 6)) begin
      op = op_t'(2'($urandom_range(0, 3)));
      ch = 3'($urandom);
      idx = 3'($urandom);
      d = 8'($urandom);
      if (op == OP_WRITE && (idx == REG_CNT_LO || idx == REG_CNT_HI) && sb.queued[ch])
        op = OP_READ;
      if (op == OP_START) d = d & startable();
      send(op, ch, idx, d);
    end
  endtask

  task automatic long_channel_run();
    wait_drained();
    while (sb.active || sb.queued != 8'd0) send(OP_TICK, 3'd0, 3'd0, 8'd0);
    tx_steady = 1'b1;
    rx_steady <= 1'b1;
    send(OP_WRITE, LONG_CH, REG_CTRL, 8'h04);
    send(OP_WRITE, LONG_CH, REG_BPORT, 8'h40);
    send(OP_WRITE, LONG_CH, REG_A_LO, 8'hF0);
    send(OP_WRITE, LONG_CH, REG_A_HI, 8'hFF);
    send(OP_WRITE, LONG_CH, REG_A_BANK, 8'hFF);
    send(OP_WRITE, LONG_CH, REG_CNT_LO, 8'h03);
    send(OP_WRITE, LONG_CH, REG_CNT_HI, 8'h00);
    send(OP_START, 3'd0, 3'd0, 8'd1 << LONG_CH);
    send(OP_TICK, 3'd0, 3'd0, 8'd0);
    send(OP_START, 3'd0, 3'd0, 8'd1 << LONG_CH);
    send(OP_WRITE, LONG_CH, REG_CNT_LO, 8'h55);
    send(OP_TICK, 3'd0, 3'd0, 8'd0);
    send(OP_TICK, 3'd0, 3'd0, 8'd0);
    send(OP_READ, LONG_CH, REG_CNT_LO, 8'd0);
    repeat (30) send(OP_TICK, 3'd7, 3'd7, 8'hFF);
    send(OP_TICK, 3'd0, 3'd0, 8'd0);
    send(OP_READ, LONG_CH, REG_A_LO, 8'd0);
    send(OP_READ, LONG_CH, REG_CNT_HI, 8'd0);
    wait_drained();
  endtask

  initial begin : main
    int goal;
    int seq;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send(OP_WRITE, 3'd0, REG_CTRL, 8'h04);
    send(OP_WRITE, 3'd0, REG_BPORT, 8'hFF);
    send(OP_WRITE, 3'd0, REG_A_LO, 8'hFF);
    send(OP_WRITE, 3'd0, REG_A_HI, 8'hFF);
    send(OP_WRITE, 3'd0, REG_A_BANK, 8'hFF);
    send(OP_WRITE, 3'd0, REG_CNT_LO, 8'h03);
    send(OP_WRITE, 3'd0, REG_CNT_HI, 8'h00);
    send(OP_WRITE, 3'd1, REG_CTRL, 8'hFF);
    send(OP_READ, 3'd1, REG_CTRL, 8'h00);
    send(OP_READ, 3'd0, REG_BPORT, 8'h00);
    send(OP_WRITE, 3'd1, REG_CTRL, 8'h93);
    send(OP_WRITE, 3'd1, REG_CNT_LO, 8'h02);
    send(OP_WRITE, 3'd1, REG_UNUSED, 8'hAA);
    send(OP_READ, 3'd1, REG_UNUSED, 8'h00);
    send(OP_TICK, 3'd0, 3'd0, 8'h00);
    send(OP_START, 3'd0, 3'd0, 8'h03);
    repeat (6) send(OP_TICK, 3'd0, 3'd0, 8'h00);
    send(OP_READ, 3'd0, REG_CNT_LO, 8'h00);
    send(OP_READ, 3'd0, REG_A_BANK, 8'h00);
    send(OP_READ, 3'd1, REG_A_LO, 8'h00);
    wait_drained();

    goal = sent_items + RANDOM_ITEMS;
    seq = 0;
    while (sent_items + backlog() < goal) begin
      seq++;
      tx_steady = ($urandom_range(0, 5) == 0);
      rx_steady <= ($urandom_range(0, 5) == 0);
      if (seq % 18 == 5) begin
        hold_reqs <= hold_reqs + 1;
        tx_steady = 1'b1;
        program_and_run();
      end else if (seq % 25 == 12) begin
        wait_drained();
        program_and_run();
      end else if ($urandom_range(0, 3) == 0) begin
        noise_burst();
      end else begin
        program_and_run();
      end
    end

    long_channel_run();
    repeat (20) @(posedge clk);

    $display("Sent %0d requests, checked %0d results, %0d of them byte copies;",
             sent_items, sb.results_seen, sb.bytes_copied);
    $display("run covered all registers, idle ticks, re-queued and zero-count channels, stalls.");
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
